// ===== rtl/tgfw_pkg.sv =====
// Shared types, codes, constants and the 5x7 font table for the text glyph framebuffer writer.
`default_nettype none

package tgfw_pkg;

    // Default geometry of the framebuffer.
    localparam int DEF_COLUMNS = 128;
    localparam int DEF_PAGES   = 8;

    // Widest page number for the largest supported page count, including the
    // saturated value one past the last page.
    localparam int PAGE_W = 5;

    localparam int GLYPH_WIDTH = 5;
    localparam int GLYPH_COUNT = 36;
    localparam int ADVANCE     = 6;
    localparam int QDEPTH      = 2;

    // Input item operation codes.
    localparam logic [2:0] OP_START      = 3'd0;
    localparam logic [2:0] OP_CHAR       = 3'd1;
    localparam logic [2:0] OP_CLEAR_PAGE = 3'd2;
    localparam logic [2:0] OP_CLEAR_ALL  = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef struct packed {
        logic [2:0] op;
        logic [6:0] column;
        logic [2:0] row;
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] cursor_column;
        logic       text_active;
    } out_item_t;

    // Work handed from the front end to the back end.
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_DRAW,
        CMD_CLR_PAGE,
        CMD_CLR_ALL,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [PAGE_W-1:0] page;
        logic [7:0]        x;
        logic [5:0]        glyph;
        logic [7:0]        cursor_column;
        logic              text_active;
    } cmd_t;

    // Maps a character code to a glyph index; bit 6 set means the code has a glyph.
    function automatic logic [6:0] glyph_lookup(input logic [7:0] code);
        logic [6:0] res;
        res = 7'd0;
        if (code >= 8'h30 && code <= 8'h39) begin
            res = {1'b1, 6'(code - 8'h30)};
        end else if (code >= 8'h41 && code <= 8'h5A) begin
            res = {1'b1, 6'(code - 8'h41 + 8'd10)};
        end else if (code >= 8'h61 && code <= 8'h7A) begin
            res = {1'b1, 6'(code - 8'h61 + 8'd10)};
        end
        return res;
    endfunction

    // Returns one 7-pixel column of a glyph; column 0 is the leftmost.
    function automatic logic [6:0] glyph_col(input logic [5:0] idx, input logic [2:0] col);
        logic [39:0] g;
        logic [7:0]  b;
        case (idx)
            6'd0:  g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
            6'd1:  g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
            6'd2:  g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
            6'd3:  g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
            6'd4:  g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
            6'd5:  g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
            6'd6:  g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
            6'd7:  g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
            6'd8:  g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            6'd9:  g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
            6'd10: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
            6'd11: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
            6'd12: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
            6'd13: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
            6'd14: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
            6'd15: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
            6'd16: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
            6'd17: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            6'd18: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            6'd19: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
            6'd20: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
            6'd21: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
            6'd22: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
            6'd23: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
            6'd24: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            6'd25: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
            6'd26: g = {8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
            6'd27: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
            6'd28: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
            6'd29: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            6'd30: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            6'd31: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            6'd32: g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
            6'd33: g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            6'd34: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
            6'd35: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
            default: g = 40'd0;
        endcase
        case (col)
            3'd0: b = g[39:32];
            3'd1: b = g[31:24];
            3'd2: b = g[23:16];
            3'd3: b = g[15:8];
            3'd4: b = g[7:0];
            default: b = 8'd0;
        endcase
        return b[6:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tgfw_queue.sv =====
// Short command queue between the front end and the back end.
`default_nettype none

module tgfw_queue
    import tgfw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output cmd_t      head_cmd
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    cmd_t          slot_reg [QDEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full      = (count_reg == CW'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tgfw_front.sv =====
// Front end: accepts items, tracks the text cursor and turns each item into a command.
`default_nettype none

module tgfw_front
    import tgfw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    input  wire logic q_full,
    input  wire logic init_busy,
    output logic      q_push,
    output cmd_t      q_cmd
);

    localparam int EDGE = COLUMNS - 5;

    logic [7:0]        cursor_x_reg, cursor_x_next;
    logic [6:0]        line_start_reg, line_start_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic              open_reg, open_next;

    logic              active;
    logic [8:0]        adv_sum;
    logic [7:0]        adv_x;
    logic [6:0]        glyph_hit;
    logic              row_ok;
    logic [PAGE_W-1:0] row_ext;
    logic              page_ok;

    assign in_ready = !q_full && !init_busy;
    assign q_push   = in_valid && in_ready;

    assign active    = open_reg && ({1'b0, cursor_x_reg} < 9'(EDGE));
    assign adv_sum   = {1'b0, cursor_x_reg} + 9'(ADVANCE);
    assign adv_x     = adv_sum[8] ? 8'hFF : adv_sum[7:0];
    assign glyph_hit = glyph_lookup(in_data.char_code);
    assign row_ext   = PAGE_W'(in_data.row);
    assign row_ok    = (row_ext < PAGE_W'(PAGES));
    assign page_ok   = (page_reg < PAGE_W'(PAGES));

    always_comb
    begin
        cursor_x_next   = cursor_x_reg;
        line_start_next = line_start_reg;
        page_next       = page_reg;
        open_next       = open_reg;
        q_cmd.kind      = CMD_NOP;
        q_cmd.page      = row_ext;
        q_cmd.x         = {1'b0, in_data.column};
        q_cmd.glyph     = glyph_hit[5:0];
        case (in_data.op)
            OP_START:
            begin
                cursor_x_next   = {1'b0, in_data.column};
                line_start_next = in_data.column;
                page_next       = row_ok ? row_ext : PAGE_W'(PAGES);
                open_next       = 1'b1;
            end
            OP_CHAR:
            begin
                if (active)
                begin
                    cursor_x_next = adv_x;
                    if (in_data.char_code != CHAR_SPACE)
                    begin
                        if (glyph_hit[6] && page_ok)
                        begin
                            q_cmd.kind = CMD_DRAW;
                            q_cmd.page = page_reg;
                            q_cmd.x    = cursor_x_reg;
                        end
                        // Wrap to the start column of the next page.
                        if (!in_data.last_char && ({1'b0, adv_x} >= 9'(EDGE)))
                        begin
                            cursor_x_next = {1'b0, line_start_reg};
                            if (page_ok)
                            begin
                                page_next = page_reg + 1'b1;
                            end
                        end
                    end
                    if (in_data.last_char)
                    begin
                        open_next = 1'b0;
                    end
                end
            end
            OP_CLEAR_PAGE:
            begin
                if (row_ok)
                begin
                    q_cmd.kind = CMD_CLR_PAGE;
                end
            end
            OP_CLEAR_ALL:
            begin
                q_cmd.kind = CMD_CLR_ALL;
            end
            OP_READ:
            begin
                if (row_ok && ({2'b0, in_data.column} < 9'(COLUMNS)))
                begin
                    q_cmd.kind = CMD_READ;
                end
            end
            default:
            begin
                q_cmd.kind = CMD_NOP;
            end
        endcase
        q_cmd.cursor_column = cursor_x_next;
        q_cmd.text_active   = open_next && ({1'b0, cursor_x_next} < 9'(EDGE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= '0;
            line_start_reg <= '0;
            page_reg       <= '0;
            open_reg       <= 1'b0;
        end
        else if (q_push)
        begin
            cursor_x_reg   <= cursor_x_next;
            line_start_reg <= line_start_next;
            page_reg       <= page_next;
            open_reg       <= open_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tgfw_back.sv =====
// Back end: owns the framebuffer memory and carries out draw, clear and read commands.
`default_nettype none

module tgfw_back
    import tgfw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_not_empty,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output logic      init_busy,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_item_t out_data
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DRAW,
        ST_READ,
        ST_DONE
    } state_t;

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    logic [2:0]      step_reg, step_next;
    logic            wr_pend_reg, wr_pend_next;
    logic [AW-1:0]   wr_addr_reg, wr_addr_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [AW-1:0]   clr_last_reg, clr_last_next;
    logic            clr_report_reg, clr_report_next;
    logic [7:0]      res_data_reg, res_data_next;
    logic            out_valid_reg, out_valid_next;
    out_item_t       out_data_reg, out_data_next;

    logic [7:0]      fb_mem [DEPTH];
    logic [7:0]      mem_rdata_reg;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]      mem_wdata;

    logic [8:0]      draw_x;
    logic            draw_ok;
    logic [AW-1:0]   draw_addr;
    logic            out_free;

    function automatic logic [AW-1:0] addr_of(input logic [PAGE_W-1:0] page,
                                              input logic [7:0] x);
        return AW'(int'(page) * COLUMNS + int'(x));
    endfunction

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign init_busy = (state_reg == ST_CLEAR) && !clr_report_reg;
    assign q_pop     = (state_reg == ST_IDLE) && q_not_empty;
    assign out_free  = !out_valid_reg || out_ready;

    assign draw_x    = {1'b0, cmd_reg.x} + 9'(step_reg);
    assign draw_ok   = (step_reg < 3'(GLYPH_WIDTH)) && (draw_x < 9'(COLUMNS));
    assign draw_addr = addr_of(cmd_reg.page, draw_x[7:0]);

    // Memory port control: one write and one read address per cycle.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = mem_rdata_reg | {1'b0, glyph_col(cmd_reg.glyph, step_reg - 3'd1)};
        mem_re    = 1'b0;
        mem_raddr = draw_addr;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = 8'd0;
            end
            ST_DRAW:
            begin
                mem_we = wr_pend_reg;
                mem_re = draw_ok;
            end
            ST_IDLE:
            begin
                mem_re    = q_pop && (q_cmd.kind == CMD_READ);
                mem_raddr = addr_of(q_cmd.page, q_cmd.x);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        step_next       = step_reg;
        wr_pend_next    = wr_pend_reg;
        wr_addr_next    = wr_addr_reg;
        clr_addr_next   = clr_addr_reg;
        clr_last_next   = clr_last_reg;
        clr_report_next = clr_report_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == clr_last_reg)
                begin
                    state_next = clr_report_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    cmd_next      = q_cmd;
                    res_data_next = 8'd0;
                    step_next     = 3'd0;
                    wr_pend_next  = 1'b0;
                    case (q_cmd.kind)
                        CMD_DRAW:
                        begin
                            state_next = ST_DRAW;
                        end
                        CMD_CLR_PAGE:
                        begin
                            clr_addr_next   = addr_of(q_cmd.page, 8'd0);
                            clr_last_next   = addr_of(q_cmd.page, 8'(COLUMNS - 1));
                            clr_report_next = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        CMD_CLR_ALL:
                        begin
                            clr_addr_next   = '0;
                            clr_last_next   = AW'(DEPTH - 1);
                            clr_report_next = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        CMD_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DRAW:
            begin
                // Read column n while column n-1 is written back.
                wr_pend_next = draw_ok;
                wr_addr_next = draw_addr;
                step_next    = step_reg + 3'd1;
                if (step_reg == 3'(GLYPH_WIDTH))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                res_data_next = mem_rdata_reg;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.read_data     = res_data_reg;
                    out_data_next.cursor_column = cmd_reg.cursor_column;
                    out_data_next.text_active   = cmd_reg.text_active;
                    state_next                  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            clr_last_reg   <= AW'(DEPTH - 1);
            clr_report_reg <= 1'b0;
            wr_pend_reg    <= 1'b0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_last_reg   <= clr_last_next;
            clr_report_reg <= clr_report_next;
            wr_pend_reg    <= wr_pend_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        wr_addr_reg  <= wr_addr_next;
        res_data_reg <= res_data_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fb_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= fb_mem[mem_raddr];
        end
    end

`ifndef SYNTH
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (int'(mem_waddr) < DEPTH))
        else $error("framebuffer write beyond the store");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (int'(mem_raddr) < DEPTH))
        else $error("framebuffer read beyond the store");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("command taken while the back end is busy");

    a_draw_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW) |-> (step_reg <= 3'(GLYPH_WIDTH)))
        else $error("draw step counter overran the glyph width");

    a_draw_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW && step_reg == 3'(GLYPH_WIDTH)) |=> (state_reg == ST_DONE))
        else $error("draw did not finish after the last column");
`endif

endmodule

`default_nettype wire

// ===== rtl/text_glyph_framebuffer_writer.sv =====
// Top level of the text glyph framebuffer writer.
`default_nettype none

// Renders 5x7 text into a page-organized monochrome framebuffer of COLUMNS
// columns by PAGES pages, one byte per column per page, bit n being pixel row
// n of the page. Each accepted input transfer produces exactly one output
// transfer, in order. A front end takes input transfers, updates the text
// cursor at once and queues a command; a back end works the commands against
// a framebuffer memory with one write and one read port and fills a single
// output register, so the input side keeps accepting while a result waits.
// In the back end, a drawn character is a read-modify-write of its five column
// bytes pipelined through the memory ports, and a page clear or a full clear
// writes one byte per cycle. After reset the framebuffer is zeroed by a sweep
// over every byte, during which in_ready stays low.
// COLUMNS ranges over 16 to 256 and PAGES over 1 to 16.
module text_glyph_framebuffer_writer
    import tgfw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int PAGES   = DEF_PAGES
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_item_t out_data
);

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic q_full;
    logic q_not_empty;
    logic pop;
    logic init_busy;

    // Cursor tracking and command classification.
    tgfw_front #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_full    (q_full),
        .init_busy (init_busy),
        .q_push    (push),
        .q_cmd     (push_cmd)
    );

    // Decouples the front end from long clears and draws in the back end.
    tgfw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // Framebuffer memory, drawing, clearing and read-back.
    tgfw_back #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (pop),
        .init_busy   (init_busy),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

`default_nettype wire

// ===== bench/text_glyph_framebuffer_writer_test.sv =====
// Self-checking testbench for the text glyph framebuffer writer: a directed table, then random text.
module text_glyph_framebuffer_writer_test;
    import tgfw_pkg::*;

    // Geometry of the instance under test and the column at which text stops.
    localparam int COLS       = DEF_COLUMNS;
    localparam int PAGE_COUNT = DEF_PAGES;
    localparam int EDGE       = COLS - 5;

    // Operation codes the block does not define; they must leave state alone.
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    // Number of random input items sent after the directed table.
    localparam int RANDOM_ITEMS = 1950;

    // The limit below sits well above the slowest correct run: about 2000
    // items, a handful of full clears, page clears, sender gaps and receiver
    // stalls, plus the sweep after reset.
    localparam int CYCLE_LIMIT = 400000;

    // The 5x7 font, glyph 0 ('0') in the top 40 bits, leftmost column first.
    // Digits take glyphs 0 to 9 and letters glyphs 10 to 35.
    localparam logic [36*40-1:0] FONT_BITS = {
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
        40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100, 40'h2040413F01,
        40'h7F08142241, 40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F,
        40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543
    };

    // One row of the directed table. When pinned is set the result is typed
    // in by hand; otherwise it comes from the predictor below.
    typedef struct {
        in_item_t  item;
        bit        pinned;
        out_item_t want;
    } table_row_t;

    typedef struct {
        bit        pinned;
        out_item_t want;
    } pinned_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    text_glyph_framebuffer_writer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // A 125 MHz-style clock: period of 8 time units.
    always #4 clk = ~clk;

    // Predictor state: its own copy of the framebuffer and the text cursor.
    logic [7:0] pixels [0:COLS*PAGE_COUNT-1];
    int         pen_x;
    int         margin_x;
    int         pen_page;
    bit         text_open;

    // Reports the block owes us, oldest first, and the hand-typed results
    // that go with each transfer the sender has put on the bus.
    out_item_t  cursor_reports [$];
    pinned_t    pinned_reports [$];
    table_row_t directed_rows [$];

    int fail_count;
    int cycle_count;
    int applied_items;
    int sent_items;
    int reports_seen;
    int glyphs_drawn;
    int wraps_taken;
    int bytes_read;
    int pages_cleared;
    int full_clears;

    // Sender burst bookkeeping and receiver stall pattern.
    int burst_left;
    int stall_mode;
    int stall_left;

    // Applies one accepted input transfer to the predictor state and returns
    // the report the block must produce for it. The applied flag is cleared
    // for items that the block only ignores.
    function automatic out_item_t render_item(input in_item_t it, output bit applied);
        out_item_t rep;
        int        glyph;
        int        code;
        int        x;
        rep     = '0;
        applied = 1'b1;
        code    = int'(it.char_code);
        case (it.op)
            OP_START:
            begin
                pen_x     = int'(it.column);
                margin_x  = int'(it.column);
                pen_page  = (int'(it.row) < PAGE_COUNT) ? int'(it.row) : PAGE_COUNT;
                text_open = 1'b1;
            end
            OP_CHAR:
            begin
                if (text_open && pen_x < EDGE)
                begin
                    if (it.char_code == CHAR_SPACE)
                    begin
                        // A space only moves the cursor; it never wraps.
                        pen_x = pen_x + ADVANCE;
                    end
                    else
                    begin
                        glyph = -1;
                        if (code >= 8'h30 && code <= 8'h39)
                            glyph = code - 8'h30;
                        else if (code >= 8'h41 && code <= 8'h5A)
                            glyph = 10 + code - 8'h41;
                        else if (code >= 8'h61 && code <= 8'h7A)
                            glyph = 10 + code - 8'h61;
                        if (glyph >= 0 && pen_page < PAGE_COUNT)
                        begin
                            glyphs_drawn++;
                            for (int i = 0; i < GLYPH_WIDTH; i++)
                            begin
                                x = pen_x + i;
                                if (x < COLS)
                                    pixels[pen_page*COLS + x] |= {1'b0,
                                        FONT_BITS[(35-glyph)*40 + 32 - 8*i +: 7]};
                            end
                        end
                        pen_x = pen_x + ADVANCE;
                        if (!it.last_char && pen_x >= EDGE)
                        begin
                            wraps_taken++;
                            pen_x = margin_x;
                            if (pen_page < PAGE_COUNT)
                                pen_page++;
                        end
                    end
                    if (pen_x > 255)
                        pen_x = 255;
                    if (it.last_char)
                        text_open = 1'b0;
                end
                else
                begin
                    applied = 1'b0;
                end
            end
            OP_CLEAR_PAGE:
            begin
                pages_cleared++;
                if (int'(it.row) < PAGE_COUNT)
                    for (int i = 0; i < COLS; i++)
                        pixels[int'(it.row)*COLS + i] = 8'h00;
            end
            OP_CLEAR_ALL:
            begin
                full_clears++;
                for (int i = 0; i < COLS*PAGE_COUNT; i++)
                    pixels[i] = 8'h00;
            end
            OP_READ:
            begin
                bytes_read++;
                if (int'(it.column) < COLS && int'(it.row) < PAGE_COUNT)
                    rep.read_data = pixels[int'(it.row)*COLS + int'(it.column)];
            end
            default:
            begin
                applied = 1'b0;
            end
        endcase
        rep.cursor_column = 8'(pen_x);
        rep.text_active   = text_open && pen_x < EDGE;
        return rep;
    endfunction

    // Every field random, then the operation forced.
    function automatic in_item_t random_item(input logic [2:0] op);
        in_item_t    it;
        logic [31:0] raw;
        raw   = $urandom;
        it    = raw[21:0];
        it.op = op;
        return it;
    endfunction

    // Character codes weighted toward the ones that draw.
    function automatic logic [7:0] random_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return 8'h41 + 8'($urandom_range(0, 25));
        else if (pick < 45)
            return 8'h61 + 8'($urandom_range(0, 25));
        else if (pick < 65)
            return 8'h30 + 8'($urandom_range(0, 9));
        else if (pick < 78)
            return CHAR_SPACE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_row(input logic [2:0] op, input int col, input int row_n,
                           input int code, input bit last, input bit pinned,
                           input int rd, input int cur, input bit act);
        table_row_t r;
        r.item.op            = op;
        r.item.column        = 7'(col);
        r.item.row           = 3'(row_n);
        r.item.char_code     = 8'(code);
        r.item.last_char     = last;
        r.pinned             = pinned;
        r.want.read_data     = 8'(rd);
        r.want.cursor_column = 8'(cur);
        r.want.text_active   = act;
        directed_rows.push_back(r);
    endtask

    // Puts one transfer on the input channel and holds it until it is taken.
    // Gaps come between bursts; within a burst valid stays high across
    // transfers, so it is never lowered and raised in the same step.
    task automatic send(input in_item_t it, input bit pinned, input out_item_t want);
        int      gap;
        pinned_t p;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sent_items++;
        p.pinned = pinned;
        p.want   = want;
        pinned_reports.push_back(p);
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    // Every accepted input transfer goes through the predictor. Inputs and
    // outputs are sampled here before any update scheduled at this edge.
    always @(posedge clk)
    begin : track_inputs
        out_item_t rep;
        pinned_t   p;
        bit        applied;
        if (rst_n && in_valid && in_ready)
        begin
            rep = render_item(in_data, applied);
            p   = pinned_reports.pop_front();
            cursor_reports.push_back(p.pinned ? p.want : rep);
            if (applied)
                applied_items++;
        end
    end

    // Compare each output transfer with the oldest outstanding report.
    always @(posedge clk)
    begin : check_outputs
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            reports_seen++;
            if (cursor_reports.size() == 0)
            begin
                $display("%0t: result with nothing outstanding: expected none, got %h",
                         $time, out_data);
                fail_count++;
            end
            else
            begin
                want = cursor_reports.pop_front();
                if (out_data.read_data !== want.read_data)
                begin
                    $display("%0t: read_data expected %02h, got %02h",
                             $time, want.read_data, out_data.read_data);
                    fail_count++;
                end
                if (out_data.cursor_column !== want.cursor_column)
                begin
                    $display("%0t: cursor_column expected %0d, got %0d",
                             $time, want.cursor_column, out_data.cursor_column);
                    fail_count++;
                end
                if (out_data.text_active !== want.text_active)
                begin
                    $display("%0t: text_active expected %0b, got %0b",
                             $time, want.text_active, out_data.text_active);
                    fail_count++;
                end
            end
        end
    end

    // The receiver cycles through stall styles: always ready, coin flips,
    // mostly stalled, and a fixed 4-of-7 pattern.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(30, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (cycle_count % 7) < 4;
        endcase
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped at cycle %0d with %0d reports outstanding",
                     cycle_count, cursor_reports.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        in_item_t it;
        int       pick;
        int       length;
        bit       close_it;

        for (int i = 0; i < COLS*PAGE_COUNT; i++)
            pixels[i] = 8'h00;
        pen_x      = 0;
        margin_x   = 0;
        pen_page   = 0;
        text_open  = 1'b0;
        burst_left = 0;
        stall_mode = 0;
        stall_left = 0;

        // Directed table: after reset, every operation, the field extremes,
        // wrapping, clipping past the last page, drawing up to the right edge,
        // dropped characters, and spaces that run into the edge.
        add_row(OP_READ,       0,   0, 8'h00, 0, 1, 8'h00, 0,   0);
        add_row(OP_CHAR,       5,   2, 8'h41, 0, 1, 8'h00, 0,   0);
        add_row(OP_START,      0,   0, 8'hFF, 1, 1, 8'h00, 0,   1);
        add_row(OP_CHAR,     127,   7, 8'h41, 0, 1, 8'h00, 6,   1);
        add_row(OP_CHAR,       0,   0, 8'h7A, 0, 0, 0, 0, 0);
        add_row(OP_CHAR,       0,   0, 8'h30, 0, 0, 0, 0, 0);
        add_row(OP_CHAR,       0,   0, 8'h39, 0, 0, 0, 0, 0);
        add_row(OP_CHAR,       0,   0, 8'h20, 0, 0, 0, 0, 0);
        add_row(OP_CHAR,       0,   0, 8'h21, 0, 0, 0, 0, 0);
        add_row(OP_CHAR,       0,   0, 8'hFF, 1, 0, 0, 0, 0);
        add_row(OP_READ,       6,   0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_START,    127,   7, 8'h00, 0, 1, 8'h00, 127, 0);
        add_row(OP_CHAR,       0,   0, 8'h42, 0, 1, 8'h00, 127, 0);
        add_row(OP_START,    117,   7, 8'h00, 0, 1, 8'h00, 117, 1);
        add_row(OP_CHAR,       0,   0, 8'h4D, 0, 0, 0, 0, 0);
        add_row(OP_CHAR,       0,   0, 8'h57, 0, 0, 0, 0, 0);
        add_row(OP_CHAR,       0,   0, 8'h35, 1, 0, 0, 0, 0);
        add_row(OP_READ,     121,   7, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_START,    122,   0, 8'h00, 0, 1, 8'h00, 122, 1);
        add_row(OP_CHAR,       0,   0, 8'h58, 1, 1, 8'h00, 128, 0);
        add_row(OP_READ,     126,   0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_START,    120,   3, 8'h00, 0, 1, 8'h00, 120, 1);
        add_row(OP_CHAR,       0,   0, 8'h20, 0, 0, 0, 0, 0);
        add_row(OP_SPARE_5,  127,   7, 8'hFF, 1, 0, 0, 0, 0);
        add_row(OP_SPARE_6,   64,   3, 8'h41, 0, 0, 0, 0, 0);
        add_row(OP_SPARE_7,    0,   0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_CLEAR_PAGE, 0,   0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_READ,       6,   0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_CLEAR_ALL,  0,   0, 8'h00, 0, 0, 0, 0, 0);
        add_row(OP_READ,     121,   7, 8'h00, 0, 0, 0, 0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[n])
            send(directed_rows[n].item, directed_rows[n].pinned, directed_rows[n].want);

        // Random part. Most of it is whole strings with random content, since
        // a string must be opened before anything gets drawn; the rest is
        // reads, clears, stray characters and undefined operations.
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                it = random_item(OP_START);
                if ($urandom_range(0, 9) < 7)
                    it.column = 7'($urandom_range(0, 110));
                send(it, 1'b0, '0);
                length   = $urandom_range(1, 25);
                close_it = $urandom_range(0, 9) != 0;
                for (int k = 0; k < length; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        send(random_item(OP_READ), 1'b0, '0);
                    end
                    it           = random_item(OP_CHAR);
                    it.char_code = random_char();
                    it.last_char = close_it && (k == length - 1);
                    send(it, 1'b0, '0);
                end
            end
            else if (pick < 88)
            begin
                send(random_item(OP_READ), 1'b0, '0);
            end
            else if (pick < 93)
            begin
                send(random_item(OP_CHAR), 1'b0, '0);
            end
            else if (pick < 96)
            begin
                send(random_item(OP_CLEAR_PAGE), 1'b0, '0);
            end
            else if (pick < 97)
            begin
                send(random_item(OP_CLEAR_ALL), 1'b0, '0);
            end
            else
            begin
                send(random_item(3'($urandom_range(OP_SPARE_5, OP_SPARE_7))), 1'b0, '0);
            end
        end
        in_valid <= 1'b0;

        // Drain, then leave room for any stray extra result to show up.
        while (cursor_reports.size() != 0 || pinned_reports.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Checked %0d results (%0d items took effect): %0d glyphs, %0d wraps,",
                 reports_seen, applied_items, glyphs_drawn, wraps_taken);
        $display("%0d byte reads, %0d page clears and %0d full clears, in %0d cycles",
                 bytes_read, pages_cleared, full_clears, cycle_count);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tgfw_pkg.sv
rtl/tgfw_queue.sv
rtl/tgfw_front.sv
rtl/tgfw_back.sv
rtl/text_glyph_framebuffer_writer.sv
bench/text_glyph_framebuffer_writer_test.sv
